/* sv/mkla_pkg.sv */
// Shared types and constants for the mask keyed layer average block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package mkla_pkg;

    // Field widths
    localparam int LEVEL_W = 8;
    localparam int LAYER_W = 4;
    localparam int COLOR_W = 8;
    localparam int COUNT_W = 5;
    localparam int USED_W  = 5;

    // Configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYER_COUNT = 1'b0,
        CFG_START_LAYER = 1'b1
    } t_cfg_idx;

    localparam logic [COUNT_W-1:0] LAYER_COUNT_RESET = 5'd16;
    localparam logic [LAYER_W-1:0] START_LAYER_RESET = 4'd0;

    // Largest value the layer count register can hold.
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;

    // Weight of one stack position against level * count.
    localparam int POS_STEP = 200;
    localparam int PROD_W   = LEVEL_W + COUNT_W;

    // The divider produces one quotient bit per step.
    localparam int DIV_STEPS = COLOR_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic pos;
        logic acc;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_stat;

    // Start layer modulo the layer count, as a short restoring remainder.
    function automatic logic [LAYER_W-1:0] start_mod(
        input logic [LAYER_W-1:0] start,
        input logic [COUNT_W-1:0] cnt
    );
        logic [COUNT_W:0] rem;
        rem = '0;
        for (int i = LAYER_W - 1; i >= 0; i--) begin
            rem = {rem[COUNT_W-1:0], start[i]};
            if (rem >= {1'b0, cnt}) begin
                rem = rem - {1'b0, cnt};
            end
        end
        return rem[LAYER_W-1:0];
    endfunction

endpackage

/* sv/mkla_in_if.sv */
// Request channel carrying one layer sample of a pixel.
// Depends on mkla_pkg for the field widths.
interface mkla_in_if;
    logic                          valid;
    logic                          ready;
    logic [mkla_pkg::LEVEL_W-1:0]  mask_level;
    logic [mkla_pkg::LAYER_W-1:0]  layer_index;
    logic [mkla_pkg::COLOR_W-1:0]  red;
    logic [mkla_pkg::COLOR_W-1:0]  green;
    logic [mkla_pkg::COLOR_W-1:0]  blue;
    logic                          last_layer;

    modport source (
        output valid, mask_level, layer_index, red, green, blue, last_layer,
        input  ready
    );
    modport sink (
        input  valid, mask_level, layer_index, red, green, blue, last_layer,
        output ready
    );
endinterface

/* sv/mkla_out_if.sv */
// Result channel carrying the averaged pixel and the number of layers used.
// Depends on mkla_pkg for the field widths.
interface mkla_out_if;
    logic                          valid;
    logic                          ready;
    logic [mkla_pkg::COLOR_W-1:0]  avg_red;
    logic [mkla_pkg::COLOR_W-1:0]  avg_green;
    logic [mkla_pkg::COLOR_W-1:0]  avg_blue;
    logic [mkla_pkg::USED_W-1:0]   used_layers;

    modport source (
        output valid, avg_red, avg_green, avg_blue, used_layers,
        input  ready
    );
    modport sink (
        input  valid, avg_red, avg_green, avg_blue, used_layers,
        output ready
    );
endinterface

/* sv/mask_keyed_layer_average.sv */
// Top level of the mask keyed layer average: joins the controller and the datapath.
// Depends on mkla_pkg, mkla_in_if, mkla_out_if, mkla_ctrl and mkla_datapath.
//
//   channel   direction  carries
//   i_in      request    mask_level, layer_index, red, green, blue, last_layer
//   o_out     result     avg_red, avg_green, avg_blue, used_layers
//   i_cfg_*   write      layer_count (index 0), start_layer (index 1)
//
// A layer sample is handled in order: capture, stack position, threshold and sum.
// The last sample of a pixel then runs the dividers (one quotient bit per cycle,
// three channels in parallel) and loads the result register once it is free.
// Reset is synchronous and active low; it needs no clearing pass.
// A result waits in its own register, so the next pixel's samples are taken
// while it is unclaimed; only a second finished result stalls behind it.
module mask_keyed_layer_average #(
    parameter int MAX_LAYERS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mkla_in_if.sink                           i_in,
    mkla_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [mkla_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mkla_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int USED_LIMIT = (MAX_LAYERS < mkla_pkg::COUNT_MAX) ? MAX_LAYERS
                                                                  : mkla_pkg::COUNT_MAX;

    mkla_pkg::t_dp_cmd  w_cmd;
    mkla_pkg::t_dp_stat w_stat;
    logic               w_in_ready;

    mkla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mkla_datapath #(
        .MAX_LAYERS (MAX_LAYERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_mask_level  (i_in.mask_level),
        .i_layer_index (i_in.layer_index),
        .i_red         (i_in.red),
        .i_green       (i_in.green),
        .i_blue        (i_in.blue),
        .i_last_layer  (i_in.last_layer),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_avg_red     (o_out.avg_red),
        .o_avg_green   (o_out.avg_green),
        .o_avg_blue    (o_out.avg_blue),
        .o_used_layers (o_out.used_layers)
    );

    assign i_in.ready = w_in_ready;

    // A new result is only loaded into a free or draining result register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten while still pending");

    // No request is taken while the dividers are running.
    a_busy_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_step |-> !i_in.ready)
        else $error("request accepted during division");

    // The tally never exceeds the effective stack depth.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (int'(o_out.used_layers) <= USED_LIMIT))
        else $error("used layer count above stack depth");

    // A pixel with no counted layer reports zero on every channel.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.used_layers == '0)) |->
            ((o_out.avg_red == '0) && (o_out.avg_green == '0) && (o_out.avg_blue == '0)))
        else $error("nonzero average with no layers used");

endmodule

/* sv/mkla_ctrl.sv */
// Sequencer for the layer average: steps each request through position and
// accumulate, and the last one of a pixel through divide and result load. Depends on mkla_pkg.
module mkla_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mkla_pkg::t_dp_stat i_stat,
    output mkla_pkg::t_dp_cmd  o_cmd
);

    localparam int STEP_W = $clog2(mkla_pkg::DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(mkla_pkg::DIV_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POS  = 5'b00010,
        S_ACC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    mkla_pkg::t_dp_cmd   cmd;
    logic                in_ready;

    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_POS;
                end
            end
            S_POS: begin
                cmd.pos = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                if (i_stat.last) begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (cmd.div_start) begin
            n_step = '0;
        end else if (cmd.div_step) begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_ready = in_ready;
    assign o_cmd      = cmd;

endmodule

/* sv/mkla_datapath.sv */
// Datapath of the layer average: configuration registers, stack position,
// threshold test, channel sums, shared-step dividers and the result register.
// Depends on mkla_pkg; driven by mkla_ctrl through t_dp_cmd.
module mkla_datapath #(
    parameter int MAX_LAYERS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mkla_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mkla_pkg::CFG_W-1:0]          i_cfg_data,
    input  mkla_pkg::t_dp_cmd                   i_cmd,
    output mkla_pkg::t_dp_stat                  o_stat,
    input  logic [mkla_pkg::LEVEL_W-1:0]        i_mask_level,
    input  logic [mkla_pkg::LAYER_W-1:0]        i_layer_index,
    input  logic [mkla_pkg::COLOR_W-1:0]        i_red,
    input  logic [mkla_pkg::COLOR_W-1:0]        i_green,
    input  logic [mkla_pkg::COLOR_W-1:0]        i_blue,
    input  logic                                i_last_layer,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mkla_pkg::COLOR_W-1:0]        o_avg_red,
    output logic [mkla_pkg::COLOR_W-1:0]        o_avg_green,
    output logic [mkla_pkg::COLOR_W-1:0]        o_avg_blue,
    output logic [mkla_pkg::USED_W-1:0]         o_used_layers
);

    localparam int CW    = mkla_pkg::COUNT_W;
    localparam int XW    = mkla_pkg::COLOR_W;
    localparam int TW    = $clog2(MAX_LAYERS + 1);
    localparam int SW    = XW + TW;
    localparam int CMPW  = (TW > CW) ? TW : CW;
    localparam int PW    = mkla_pkg::PROD_W;
    localparam int CLAMP = (MAX_LAYERS < mkla_pkg::COUNT_MAX) ? MAX_LAYERS
                                                             : mkla_pkg::COUNT_MAX;

    // One restoring step: shift the next dividend bit into the remainder.
    function automatic logic [TW+XW-1:0] div_step(
        input logic [TW-1:0] rem,
        input logic [XW-1:0] quo,
        input logic [TW-1:0] den
    );
        logic [TW:0] trial;
        logic        ge;
        logic [TW:0] diff;
        trial = {rem, quo[XW-1]};
        ge    = (trial >= {1'b0, den});
        diff  = trial - {1'b0, den};
        return {ge ? diff[TW-1:0] : trial[TW-1:0], quo[XW-2:0], ge};
    endfunction

    // Configuration
    logic [CW-1:0]                    r_layer_count;
    logic [mkla_pkg::LAYER_W-1:0]     r_start_layer;

    // Captured request
    logic [mkla_pkg::LEVEL_W-1:0]     r_level;
    logic [mkla_pkg::LAYER_W-1:0]     r_layer;
    logic [XW-1:0]                    r_red, r_green, r_blue;
    logic                             r_last;

    // Position stage
    logic [CW-1:0]                    r_pos;
    logic [CW-1:0]                    r_count;
    logic                             r_in_range;

    // Running sums
    logic [SW-1:0]                    r_sum_red, r_sum_green, r_sum_blue;
    logic [TW-1:0]                    r_tally;

    // Dividers
    logic [TW-1:0]                    r_rem_red, r_rem_green, r_rem_blue;
    logic [XW-1:0]                    r_quo_red, r_quo_green, r_quo_blue;
    logic [TW-1:0]                    r_div_tally;

    // Result register
    logic                             r_out_valid;
    logic [XW-1:0]                    r_avg_red, r_avg_green, r_avg_blue;
    logic [mkla_pkg::USED_W-1:0]      r_used;

    logic [CW-1:0]                    eff_count;
    logic [mkla_pkg::LAYER_W-1:0]     shift;
    logic [CW:0]                      pos_sum;
    logic [CW-1:0]                    pos;
    logic                             in_range;
    logic [PW-1:0]                    pos_weight, level_weight;
    logic                             counted;
    logic [SW-1:0]                    n_sum_red, n_sum_green, n_sum_blue;
    logic [TW-1:0]                    n_tally;
    logic [TW+XW-1:0]                 step_red, step_green, step_blue;
    logic                             out_free;

    // Layer count 0 behaves as 1, and counts above the stack depth saturate.
    always_comb begin
        if (r_layer_count == '0) begin
            eff_count = CW'(1);
        end else if (int'(r_layer_count) > CLAMP) begin
            eff_count = CW'(CLAMP);
        end else begin
            eff_count = r_layer_count;
        end
    end

    assign shift   = mkla_pkg::start_mod(r_start_layer, eff_count);
    // The shift lies below the count, and so does an in-range layer, so one subtract wraps it.
    assign pos_sum = (CW+1)'(r_layer) + (CW+1)'(eff_count) - (CW+1)'(shift);
    assign pos     = (pos_sum >= (CW+1)'(eff_count)) ? CW'(pos_sum - (CW+1)'(eff_count))
                                                     : pos_sum[CW-1:0];
    assign in_range = (CW'(r_layer) < eff_count) && (CMPW'(r_tally) < CMPW'(eff_count));

    assign pos_weight   = PW'(r_pos) * PW'(mkla_pkg::POS_STEP);
    assign level_weight = PW'(r_level) * PW'(r_count);
    assign counted      = r_in_range && (pos_weight <= level_weight);

    assign n_sum_red   = r_sum_red   + (counted ? SW'(r_red)   : '0);
    assign n_sum_green = r_sum_green + (counted ? SW'(r_green) : '0);
    assign n_sum_blue  = r_sum_blue  + (counted ? SW'(r_blue)  : '0);
    assign n_tally     = r_tally     + (counted ? TW'(1)       : '0);

    assign step_red   = div_step(r_rem_red,   r_quo_red,   r_div_tally);
    assign step_green = div_step(r_rem_green, r_quo_green, r_div_tally);
    assign step_blue  = div_step(r_rem_blue,  r_quo_blue,  r_div_tally);

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= mkla_pkg::LAYER_COUNT_RESET;
            r_start_layer <= mkla_pkg::START_LAYER_RESET;
        end else if (i_cfg_we) begin
            unique case (mkla_pkg::t_cfg_idx'(i_cfg_index))
                mkla_pkg::CFG_LAYER_COUNT: r_layer_count <= i_cfg_data;
                mkla_pkg::CFG_START_LAYER:
                    r_start_layer <= i_cfg_data[mkla_pkg::LAYER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_level <= i_mask_level;
            r_layer <= i_layer_index;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_last  <= i_last_layer;
        end
        if (i_cmd.pos) begin
            r_pos      <= pos;
            r_count    <= eff_count;
            r_in_range <= in_range;
        end
    end

    // The last sample hands its updated sums to the dividers and clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_red   <= '0;
            r_sum_green <= '0;
            r_sum_blue  <= '0;
            r_tally     <= '0;
        end else if (i_cmd.acc) begin
            if (i_cmd.div_start) begin
                r_sum_red   <= '0;
                r_sum_green <= '0;
                r_sum_blue  <= '0;
                r_tally     <= '0;
            end else begin
                r_sum_red   <= n_sum_red;
                r_sum_green <= n_sum_green;
                r_sum_blue  <= n_sum_blue;
                r_tally     <= n_tally;
            end
        end
    end

    // Each sum is below 256 times the tally, so its upper bits already form a
    // remainder smaller than the divisor and only eight quotient bits remain.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem_red   <= n_sum_red[SW-1:XW];
            r_rem_green <= n_sum_green[SW-1:XW];
            r_rem_blue  <= n_sum_blue[SW-1:XW];
            r_quo_red   <= n_sum_red[XW-1:0];
            r_quo_green <= n_sum_green[XW-1:0];
            r_quo_blue  <= n_sum_blue[XW-1:0];
            r_div_tally <= n_tally;
        end else if (i_cmd.div_step) begin
            {r_rem_red,   r_quo_red}   <= step_red;
            {r_rem_green, r_quo_green} <= step_green;
            {r_rem_blue,  r_quo_blue}  <= step_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // A zero divisor leaves an all-ones quotient, so an empty pixel reads zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_avg_red   <= (r_div_tally == '0) ? '0 : r_quo_red;
            r_avg_green <= (r_div_tally == '0) ? '0 : r_quo_green;
            r_avg_blue  <= (r_div_tally == '0) ? '0 : r_quo_blue;
            r_used      <= mkla_pkg::USED_W'(r_div_tally);
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_avg_red     = r_avg_red;
    assign o_avg_green   = r_avg_green;
    assign o_avg_blue    = r_avg_blue;
    assign o_used_layers = r_used;

endmodule
